// ===== design/clbg_pkg.sv =====
// Shared types, constants and lookup functions for the character-LCD bar graph writer.
// No dependencies; imported by clbg_step_unit and char_lcd_bar_graph_writer.
package clbg_pkg;

  // LCD instruction that sets the display data address
  localparam logic [7:0] CMD_SET_ADDR = 8'h80;

  // Character codes
  localparam logic [7:0] CH_FULL    = 8'hFF;
  localparam logic [7:0] CH_PARTIAL = 8'h01;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_PERCENT = 8'h25;

  // Screen layout
  localparam logic [4:0] BAR_CELLS = 5'd14;
  localparam logic [4:0] VALUE_COL = 5'd14;
  localparam logic [4:0] DIGIT_COL = 5'd16;
  localparam logic [4:0] PCT_COL   = 5'd19;
  localparam logic [6:0] PCT_MAX   = 7'd100;

  // Divisors fed to the shared subtract unit
  localparam logic [6:0] DIV_CELL = 7'd7;
  localparam logic [6:0] DIV_HUND = 7'd100;
  localparam logic [6:0] DIV_TEN  = 7'd10;

  // Index of the last error byte; index 0 is the cursor command
  localparam logic [3:0] ERR_LAST = 4'd15;

  // Result of one subtract step
  typedef struct packed {
    logic       ge;
    logic [6:0] diff;
  } step_t;

  // Set-address command for a line and column
  function automatic logic [7:0] goto_byte(input logic [1:0] row, input logic [4:0] col);
    logic [6:0] base;
    case (row)
      2'd0:    base = 7'd0;
      2'd1:    base = 7'd64;
      2'd2:    base = 7'd20;
      default: base = 7'd84;
    endcase
    return CMD_SET_ADDR | {1'b0, base + {2'b00, col}};
  endfunction

  // Characters of the error text "Bar Value Error"
  function automatic logic [7:0] err_char(input logic [3:0] idx);
    logic [7:0] ch;
    case (idx)
      4'd0:    ch = 8'h42; // B
      4'd1:    ch = 8'h61; // a
      4'd2:    ch = 8'h72; // r
      4'd3:    ch = 8'h20;
      4'd4:    ch = 8'h56; // V
      4'd5:    ch = 8'h61; // a
      4'd6:    ch = 8'h6C; // l
      4'd7:    ch = 8'h75; // u
      4'd8:    ch = 8'h65; // e
      4'd9:    ch = 8'h20;
      4'd10:   ch = 8'h45; // E
      4'd11:   ch = 8'h72; // r
      4'd12:   ch = 8'h72; // r
      4'd13:   ch = 8'h6F; // o
      4'd14:   ch = 8'h72; // r
      default: ch = 8'h20;
    endcase
    return ch;
  endfunction

endpackage

// ===== design/clbg_step_unit.sv =====
// Shared compare-and-subtract unit used for bar cells and decimal digits.
// Depends on clbg_pkg for the step result type.
module clbg_step_unit (
  input  logic [6:0]     acc,
  input  logic [6:0]     sub,
  output clbg_pkg::step_t step
);
  import clbg_pkg::*;

  logic [7:0] diff_wide;

  // Subtract with borrow; no borrow means acc >= sub
  assign diff_wide = {1'b0, acc} - {1'b0, sub};
  assign step.ge   = ~diff_wide[7];
  assign step.diff = diff_wide[6:0];

endmodule

// ===== design/char_lcd_bar_graph_writer.sv =====
// Top level of the character-LCD bar graph writer: sequencer and output register.
// Depends on clbg_pkg and clbg_step_unit.
//
//   channel | dir | fields
//   s_*     | in  | tdata: row[1:0], percent[8:2]
//   m_*     | out | tdata: lcd_byte[7:0]; tuser: is_data; tlast: last
//
// One item is 24 to 46 bytes long. The single output register passes one byte
// per cycle while m_tready is high, and the shared subtract unit runs one step
// per cycle while the decimal digits form.
// rst clears the sequencer and the output valid. A stall on m_tready holds the
// sequencer; s_tready is high only between items.
module char_lcd_bar_graph_writer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // row[1:0], percent[8:2], zero[15:9]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // lcd_byte[7:0]
  output logic        m_tuser,   // is_data[0]
  output logic        m_tlast
);
  import clbg_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_ERR      = 4'd1;
  localparam logic [3:0] S_BAR_GOTO = 4'd2;
  localparam logic [3:0] S_BAR      = 4'd3;
  localparam logic [3:0] S_PAD      = 4'd4;
  localparam logic [3:0] S_VAL_GOTO = 4'd5;
  localparam logic [3:0] S_SPACES   = 4'd6;
  localparam logic [3:0] S_DIV      = 4'd7;
  localparam logic [3:0] S_DIG_GOTO = 4'd8;
  localparam logic [3:0] S_DIG      = 4'd9;
  localparam logic [3:0] S_PCT_GOTO = 4'd10;
  localparam logic [3:0] S_PCT      = 4'd11;

  logic [3:0] state, state_next;
  logic [1:0] row;
  logic [6:0] pct;
  logic [6:0] acc, acc_next;
  logic [4:0] cells, cells_next;
  logic [3:0] cnt, cnt_next;
  logic       pass, pass_next;
  logic       hund, hund_next;
  logic [3:0] tens, tens_next;

  logic       emit;
  logic [7:0] emit_byte;
  logic       emit_data;
  logic       emit_last;
  logic       out_free;
  logic       advance;
  logic [6:0] sub;
  logic [3:0] digit;
  step_t      step;

  clbg_step_unit u_step (
    .acc  (acc),
    .sub  (sub),
    .step (step)
  );

  assign s_tready = (state == S_IDLE);
  assign out_free = ~m_tvalid | m_tready;
  assign advance  = ~emit | out_free;

  // Pick the divisor for the shared unit
  always_comb begin
    if (state == S_BAR) begin
      sub = DIV_CELL;
    end else if (!pass) begin
      sub = DIV_HUND;
    end else begin
      sub = DIV_TEN;
    end
  end

  // Digit at the current position: hundreds, tens, then ones left in acc
  always_comb begin
    case (cnt[1:0])
      2'd0:    digit = {3'b000, hund};
      2'd1:    digit = tens;
      default: digit = acc[3:0];
    endcase
  end

  // Sequencer: choose the byte to emit and the next state
  always_comb begin
    state_next = state;
    acc_next   = acc;
    cells_next = cells;
    cnt_next   = cnt;
    pass_next  = pass;
    hund_next  = hund;
    tens_next  = tens;
    emit       = 1'b0;
    emit_byte  = CH_SPACE;
    emit_data  = 1'b1;
    emit_last  = 1'b0;
    case (state)
      S_IDLE: begin
        cnt_next = 4'd0;
        if (s_tvalid) begin
          state_next = (s_tdata[8:2] > PCT_MAX) ? S_ERR : S_BAR_GOTO;
        end
      end
      S_ERR: begin
        emit = 1'b1;
        if (cnt == 4'd0) begin
          emit_byte = goto_byte(row, 5'd0);
          emit_data = 1'b0;
        end else begin
          emit_byte = err_char(cnt - 4'd1);
        end
        cnt_next = cnt + 4'd1;
        if (cnt == ERR_LAST) begin
          state_next = S_BAR_GOTO;
        end
      end
      S_BAR_GOTO: begin
        emit       = 1'b1;
        emit_byte  = goto_byte(row, 5'd0);
        emit_data  = 1'b0;
        acc_next   = pct;
        cells_next = 5'd0;
        state_next = S_BAR;
      end
      S_BAR: begin
        // Peel off one full cell per step; the remainder decides the partial glyph
        if (step.ge) begin
          emit       = 1'b1;
          emit_byte  = CH_FULL;
          acc_next   = step.diff;
          cells_next = cells + 5'd1;
        end else begin
          emit       = acc[2];
          emit_byte  = CH_PARTIAL;
          cells_next = cells + {4'd0, acc[2]};
          state_next = S_PAD;
        end
      end
      S_PAD: begin
        if (cells < BAR_CELLS) begin
          emit       = 1'b1;
          cells_next = cells + 5'd1;
        end else begin
          state_next = S_VAL_GOTO;
        end
      end
      S_VAL_GOTO: begin
        emit       = 1'b1;
        emit_byte  = goto_byte(row, VALUE_COL);
        emit_data  = 1'b0;
        cnt_next   = 4'd0;
        state_next = S_SPACES;
      end
      S_SPACES: begin
        emit     = 1'b1;
        cnt_next = cnt + 4'd1;
        if (cnt == 4'd3) begin
          acc_next   = pct;
          pass_next  = 1'b0;
          hund_next  = 1'b0;
          tens_next  = 4'd0;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        // Repeated subtraction of 100, then of 10
        if (step.ge) begin
          acc_next = step.diff;
          if (!pass) begin
            hund_next = 1'b1;
          end else begin
            tens_next = tens + 4'd1;
          end
        end else if (!pass) begin
          pass_next = 1'b1;
        end else begin
          state_next = S_DIG_GOTO;
        end
      end
      S_DIG_GOTO: begin
        // First digit position: 0 for three digits, 1 for two, 2 for one
        emit      = 1'b1;
        emit_data = 1'b0;
        if (hund) begin
          cnt_next = 4'd0;
        end else if (tens != 4'd0) begin
          cnt_next = 4'd1;
        end else begin
          cnt_next = 4'd2;
        end
        emit_byte  = goto_byte(row, DIGIT_COL + {1'b0, cnt_next});
        state_next = S_DIG;
      end
      S_DIG: begin
        emit      = 1'b1;
        emit_byte = CH_ZERO + {4'd0, digit};
        cnt_next  = cnt + 4'd1;
        if (cnt[1:0] == 2'd2) begin
          state_next = S_PCT_GOTO;
        end
      end
      S_PCT_GOTO: begin
        emit       = 1'b1;
        emit_byte  = goto_byte(row, PCT_COL);
        emit_data  = 1'b0;
        state_next = S_PCT;
      end
      S_PCT: begin
        emit       = 1'b1;
        emit_byte  = CH_PERCENT;
        emit_last  = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Advance the sequencer when its byte, if any, fits in the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      row <= s_tdata[1:0];
      pct <= s_tdata[8:2];
    end
    if (advance) begin
      acc   <= acc_next;
      cells <= cells_next;
      cnt   <= cnt_next;
      pass  <= pass_next;
      hund  <= hund_next;
      tens  <= tens_next;
    end
  end

  // Output register: load on emit, drop valid once the transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit && out_free) begin
      m_tdata <= emit_byte;
      m_tuser <= emit_data;
      m_tlast <= emit_last;
    end
  end

  // The closing byte of every item is the percent sign as data
  a_last_is_pct: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser && (m_tdata == CH_PERCENT))
    else $error("last byte is not the percent sign");

  // An accepted item keeps the input closed on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input reopened right after accept");

  // The tens count and the ones left in acc are decimal digits
  a_tens_digit: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIG) |-> (tens <= 4'd9) && (acc <= 7'd9))
    else $error("digit out of range");

  // The bar never holds more than nineteen cells
  a_cells_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_BAR) || (state == S_PAD) |-> cells <= 5'd19)
    else $error("bar cell count overflow");

endmodule
